### rtl/core/bsqrt_pkg.sv
// package for the binary64 square root pipeline
// holds format constants and the per-stage payload type; no dependencies
`default_nettype none
package bsqrt_pkg;
    localparam logic [63:0] CANON_NAN = 64'h7ff8_0000_0000_0000;
    localparam int ROOT_BITS = 54;
    localparam int NORM_STAGES = 6;
    localparam int DEF_BITS_PER_STAGE = 2;

    typedef struct packed {
        logic        special;
        logic [63:0] special_val;
        logic [10:0] out_exp;
        logic [53:0] m;
        logic [5:0]  lz;
        logic        odd;
    } t_pre;

    typedef struct packed {
        logic        special;
        logic [63:0] special_val;
        logic [10:0] out_exp;
        logic [107:0] rad;
        logic [55:0] r;
        logic [53:0] q;
    } t_rec;
endpackage
`default_nettype wire

### rtl/core/binary64_square_root.sv
// binary64 square root, round to nearest even, as a stall-able pipeline
// uses bsqrt_pkg for constants and stage payload types
`default_nettype none
// Takes one binary64 pattern per cycle on the slave side and returns its
// correctly rounded square root on the master side; NaN and negative inputs
// give the canonical quiet NaN, zeros and plus infinity pass through.
// Six shift stages normalize subnormals, then each recurrence stage resolves
// BITS_PER_STAGE root bits, then rounding feeds the output register.
// A new request may enter every cycle; a stall holds the whole pipeline.
module binary64_square_root #(
    parameter int BITS_PER_STAGE = bsqrt_pkg::DEF_BITS_PER_STAGE
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // [63:0] operand_bits
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] root_bits
);
    localparam int REC_STAGES = (bsqrt_pkg::ROOT_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
    localparam int NS = bsqrt_pkg::NORM_STAGES;

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // input decode
    logic [10:0] d_expf;
    logic [51:0] d_frac;
    bsqrt_pkg::t_pre d_pre;
    logic [11:0] d_e;
    always_comb begin
        d_expf = s_axis_tdata[62:52];
        d_frac = s_axis_tdata[51:0];
        d_pre = '0;
        d_pre.lz = '0;
        if (d_expf == 11'h7ff) begin
            d_pre.special = 1'b1;
            d_pre.special_val = (d_frac != '0 || s_axis_tdata[63]) ? bsqrt_pkg::CANON_NAN
                                                                   : s_axis_tdata;
        end else if (s_axis_tdata[62:0] == '0) begin
            d_pre.special = 1'b1;
            d_pre.special_val = s_axis_tdata;
        end else if (s_axis_tdata[63]) begin
            d_pre.special = 1'b1;
            d_pre.special_val = bsqrt_pkg::CANON_NAN;
        end
        // e_unbiased + 1023 before subnormal shift; subnormal counts as exp 1
        d_e = (d_expf == '0) ? 12'd1 : {1'b0, d_expf};
        d_pre.m = {1'b0, (d_expf != '0), d_frac};
        d_pre.out_exp = d_e[10:0];
        d_pre.odd = 1'b0;
    end

    // normalize stages: stage k shifts by 2^(5-k) if the top bits are clear
    bsqrt_pkg::t_pre r_pre [NS];
    logic r_pv [NS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_pv[k] <= 1'b0;
        end else if (adv) begin
            r_pv[0] <= s_axis_tvalid;
            for (int k = 1; k < NS; k++) r_pv[k] <= r_pv[k-1];
        end
    end
    for (genvar k = 0; k < NS; k++) begin : g_norm
        bsqrt_pkg::t_pre n_src;
        bsqrt_pkg::t_pre n_p;
        if (k == 0) begin : g_first
            assign n_src = d_pre;
        end else begin : g_next
            assign n_src = r_pre[k-1];
        end
        always_comb begin
            n_p = n_src;
            if (n_p.m[52 -: (1 << (5-k))] == '0) begin
                n_p.m = n_p.m << (1 << (5-k));
                n_p.lz = n_p.lz + 6'(1 << (5-k));
            end
        end
        always_ff @(posedge i_clk) if (adv) r_pre[k] <= n_p;
    end

    // exponent halving and radicand setup
    bsqrt_pkg::t_rec s_rec;
    logic signed [13:0] s_e;
    always_comb begin
        bsqrt_pkg::t_pre p;
        p = r_pre[NS-1];
        s_e = $signed({3'b0, p.out_exp}) - 14'sd1023 - $signed({8'b0, p.lz});
        s_rec.special = p.special;
        s_rec.special_val = p.special_val;
        s_rec.rad = s_e[0] ? ({2'b0, p.m[52:0], 53'b0} << 1) : {2'b0, p.m[52:0], 53'b0};
        s_rec.rad = s_rec.rad << 1;
        s_rec.out_exp = 11'((s_e - (s_e[0] ? 14'sd1 : 14'sd0)) >>> 1) + 11'd1023;
        s_rec.r = '0;
        s_rec.q = '0;
    end

    // digit recurrence stages
    bsqrt_pkg::t_rec r_rec [REC_STAGES];
    logic r_rv [REC_STAGES];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < REC_STAGES; k++) r_rv[k] <= 1'b0;
        end else if (adv) begin
            r_rv[0] <= r_pv[NS-1];
            for (int k = 1; k < REC_STAGES; k++) r_rv[k] <= r_rv[k-1];
        end
    end
    for (genvar k = 0; k < REC_STAGES; k++) begin : g_rec
        bsqrt_pkg::t_rec n_src;
        bsqrt_pkg::t_rec n_s;
        if (k == 0) begin : g_first
            assign n_src = s_rec;
        end else begin : g_next
            assign n_src = r_rec[k-1];
        end
        always_comb begin
            logic [55:0] trial;
            trial = '0;
            n_s = n_src;
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                if (k * BITS_PER_STAGE + b < bsqrt_pkg::ROOT_BITS) begin
                    n_s.r = {n_s.r[53:0], n_s.rad[107:106]};
                    n_s.rad = n_s.rad << 2;
                    trial = {n_s.q, 2'b01};
                    if (n_s.r >= trial) begin
                        n_s.r = n_s.r - trial;
                        n_s.q = {n_s.q[52:0], 1'b1};
                    end else begin
                        n_s.q = {n_s.q[52:0], 1'b0};
                    end
                end
            end
        end
        always_ff @(posedge i_clk) if (adv) r_rec[k] <= n_s;
    end

    // round and pack into the output register
    logic [63:0] n_out;
    always_comb begin
        bsqrt_pkg::t_rec f;
        logic [52:0] mant;
        f = r_rec[REC_STAGES-1];
        mant = f.q[53:1];
        if (f.q[0] && (f.r != '0 || mant[0])) mant = mant + 53'd1;
        n_out = f.special ? f.special_val
                          : ({1'b0, f.out_exp, 52'b0} + {11'b0, mant} - 64'h0010_0000_0000_0000);
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (adv) begin
            m_axis_tvalid <= r_rv[REC_STAGES-1];
        end
        if (adv) m_axis_tdata <= n_out;
    end
endmodule
`default_nettype wire
